// ----- hw/rtl/scvr_pkg.sv -----
// Shared widths, types and constants of the contact velocity response unit.
// No dependencies; every other file of the block imports this package.
package scvr_pkg;

	localparam int AXES   = 3;
	localparam int VEL_W  = 32;
	localparam int NRM_W  = 16;
	localparam int ROOT_W = 32;
	localparam int MAG_W  = ROOT_W;
	localparam int T_W    = 48;
	localparam int BASE_W = 47;
	localparam int CAP_W  = 47;
	localparam int SH_W   = 5;
	localparam int SH_MAX = 17;

	typedef logic signed [VEL_W-1:0]  vel_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;
	typedef logic signed [BASE_W-1:0] base_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic [SH_W-1:0]          shamt_t;

	localparam vel_t ONE_Q16 = 32'sd65536;
	localparam vel_t VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam vel_t VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

	// Fields that ride along the square root pipeline.
	typedef struct packed {
		mag_t [AXES-1:0]  mag;
		logic [AXES-1:0]  neg;
		base_t [AXES-1:0] base;
		logic [CAP_W-1:0] cap_sh;
		shamt_t           sh;
		logic             rub;
		logic             bnc;
	} sq_side_t;

	// Fields that ride along the divider pipeline.
	typedef struct packed {
		logic [AXES-1:0]  neg;
		base_t [AXES-1:0] base;
		shamt_t           sh;
		logic             rub;
		logic             bnc;
	} dv_side_t;

endpackage

// ----- hw/rtl/scvr_ifs.sv -----
// Valid/ready channel interfaces for contact items and velocity results.
// Depends on scvr_pkg for the field types.
interface scvr_item_if import scvr_pkg::*; ();
	logic valid;
	logic ready;
	vel_t vel_x;
	vel_t vel_y;
	vel_t vel_z;
	nrm_t normal_x;
	nrm_t normal_y;
	nrm_t normal_z;
	vel_t bounce_coeff;
	vel_t friction_coeff;

	modport source(output valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
		bounce_coeff, friction_coeff, input ready);
	modport sink(input valid, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
		bounce_coeff, friction_coeff, output ready);
endinterface

interface scvr_result_if import scvr_pkg::*; ();
	logic valid;
	logic ready;
	vel_t out_vel_x;
	vel_t out_vel_y;
	vel_t out_vel_z;
	logic bounced;
	logic rubbed;

	modport source(output valid, out_vel_x, out_vel_y, out_vel_z, bounced, rubbed,
		input ready);
	modport sink(input valid, out_vel_x, out_vel_y, out_vel_z, bounced, rubbed,
		output ready);
endinterface

// ----- hw/rtl/scvr_isqrt.sv -----
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on scvr_pkg; carries a sideband of any packed type along.
module scvr_isqrt import scvr_pkg::*; #(
	parameter int  RootW  = ROOT_W,
	parameter type side_t = logic
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [2*RootW-1:0] rad,
	input  side_t              in_side,
	output logic               out_vld,
	output logic [RootW-1:0]   root,
	output side_t              out_side
);

	localparam int RadW = 2 * RootW;

	logic [RootW-1:0] vld_s;
	logic [RadW-1:0]  rem_s   [RootW];
	logic [RootW-1:0] root_s  [RootW];
	side_t            side_s  [RootW];

	logic [RadW-1:0]  cur_rem  [RootW];
	logic [RootW-1:0] cur_root [RootW];
	side_t            cur_side [RootW];
	logic [RadW-1:0]  nxt_rem  [RootW];
	logic [RootW-1:0] nxt_root [RootW];

	always_comb begin
		logic [RadW:0] test;
		logic          take;
		cur_rem[0]  = rad;
		cur_root[0] = '0;
		cur_side[0] = in_side;
		for (int j = 1; j < RootW; j++) begin
			cur_rem[j]  = rem_s[j-1];
			cur_root[j] = root_s[j-1];
			cur_side[j] = side_s[j-1];
		end
		for (int j = 0; j < RootW; j++) begin
			// Trial root adds bit b: the square grows by (2*root + 2^b) * 2^b.
			test = (((RadW+1)'(cur_root[j]) << 1) + ((RadW+1)'(1) << (RootW-1-j)))
				<< (RootW-1-j);
			take = (RadW+1)'(cur_rem[j]) >= test;
			nxt_rem[j]  = take ? cur_rem[j] - test[RadW-1:0] : cur_rem[j];
			nxt_root[j] = take ? cur_root[j] | (RootW'(1) << (RootW-1-j)) : cur_root[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RootW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < RootW; j++) begin
				rem_s[j]  <= nxt_rem[j];
				root_s[j] <= nxt_root[j];
				side_s[j] <= cur_side[j];
			end
		end
	end

	assign out_vld  = vld_s[RootW-1];
	assign root     = root_s[RootW-1];
	assign out_side = side_s[RootW-1];

endmodule

// ----- hw/rtl/scvr_div.sv -----
// Pipelined restoring divider over several lanes sharing one divisor.
// Depends on scvr_pkg; the quotient must fit QuotW bits (high half < divisor).
module scvr_div import scvr_pkg::*; #(
	parameter int  QuotW  = ROOT_W,
	parameter int  Lanes  = AXES,
	parameter type side_t = logic
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [2*QuotW-1:0] num [Lanes],
	input  logic [QuotW-1:0]   den,
	input  side_t              in_side,
	output logic               out_vld,
	output logic [QuotW-1:0]   quot [Lanes],
	output side_t              out_side
);

	logic [QuotW-1:0] vld_s;
	logic [QuotW-1:0] rem_s  [QuotW][Lanes];
	logic [QuotW-1:0] ql_s   [QuotW][Lanes];
	logic [QuotW-1:0] den_s  [QuotW];
	side_t            side_s [QuotW];

	logic [QuotW-1:0] cur_rem  [QuotW][Lanes];
	logic [QuotW-1:0] cur_ql   [QuotW][Lanes];
	logic [QuotW-1:0] cur_den  [QuotW];
	side_t            cur_side [QuotW];
	logic [QuotW-1:0] nxt_rem  [QuotW][Lanes];
	logic [QuotW-1:0] nxt_ql   [QuotW][Lanes];

	always_comb begin
		logic [QuotW:0] trial;
		logic           take;
		cur_den[0]  = den;
		cur_side[0] = in_side;
		for (int l = 0; l < Lanes; l++) begin
			cur_rem[0][l] = num[l][2*QuotW-1:QuotW];
			cur_ql[0][l]  = num[l][QuotW-1:0];
		end
		for (int j = 1; j < QuotW; j++) begin
			cur_den[j]  = den_s[j-1];
			cur_side[j] = side_s[j-1];
			cur_rem[j]  = rem_s[j-1];
			cur_ql[j]   = ql_s[j-1];
		end
		// The low word shifts out at the top while quotient bits enter at the bottom.
		for (int j = 0; j < QuotW; j++) begin
			for (int l = 0; l < Lanes; l++) begin
				trial = {cur_rem[j][l], cur_ql[j][l][QuotW-1]};
				take  = trial >= {1'b0, cur_den[j]};
				nxt_rem[j][l] = take ? QuotW'(trial - {1'b0, cur_den[j]}) : trial[QuotW-1:0];
				nxt_ql[j][l]  = {cur_ql[j][l][QuotW-2:0], take};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QuotW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QuotW; j++) begin
				rem_s[j]  <= nxt_rem[j];
				ql_s[j]   <= nxt_ql[j];
				den_s[j]  <= cur_den[j];
				side_s[j] <= cur_side[j];
			end
		end
	end

	assign out_vld  = vld_s[QuotW-1];
	assign quot     = ql_s[QuotW-1];
	assign out_side = side_s[QuotW-1];

endmodule

// ----- hw/rtl/static_contact_velocity_response_unit.sv -----
// Contact velocity response against a static surface, fully pipelined.
// Depends on scvr_pkg, scvr_ifs (channels), scvr_isqrt and scvr_div.
//
// Usage: each transaction on the item channel carries one body velocity
// (Q16.16), a unit contact normal (Q2.14), a restitution and a friction
// coefficient. Each one produces exactly one transaction on the result
// channel, in order: the saturated velocity after the bounce and the
// friction stage, with flags that tell which of the two acted.
// The user writes the min_impact_speed register through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// Friction acts only on approaches faster than it. A new item is taken
// every cycle unless the pipeline holds. The pipeline includes the 32-stage
// square root of the tangent length and the 32-stage rescaling divider.
// All stages advance together: while a result is held on the output
// register and the receiver is not ready, the whole pipeline holds and the
// item channel drops ready, so nothing is lost or repeated. Reset clears
// every valid bit and sets min_impact_speed to zero.
module static_contact_velocity_response_unit import scvr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VEL_W-1:0]   cfg_wdata,
	scvr_item_if.sink          item,
	scvr_result_if.source      result
);

	logic en;
	vel_t min_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
		end else if (cfg_we) begin
			min_q <= vel_t'(cfg_wdata);
		end
	end

	// Input field views.
	vel_t vin [AXES];
	nrm_t nin [AXES];
	assign vin[0] = item.vel_x;
	assign vin[1] = item.vel_y;
	assign vin[2] = item.vel_z;
	assign nin[0] = item.normal_x;
	assign nin[1] = item.normal_y;
	assign nin[2] = item.normal_z;

	// Stage 1: products v_i * n_i, clamped restitution as (1 + e), threshold.
	logic               vld_s1;
	vel_t               v_s1    [AXES];
	nrm_t               n_s1    [AXES];
	logic signed [47:0] vnp_s1  [AXES];
	logic signed [18:0] ope_s1;
	vel_t               mu_s1;
	logic [44:0]        thr_s1;

	logic signed [18:0] ope_c;
	always_comb begin
		if (item.bounce_coeff[VEL_W-1]) begin
			ope_c = 19'(ONE_Q16);
		end else if (item.bounce_coeff > ONE_Q16) begin
			ope_c = 19'(ONE_Q16) + 19'(ONE_Q16);
		end else begin
			ope_c = 19'(ONE_Q16) + 19'(item.bounce_coeff);
		end
	end

	// Stage 2: normal speed vn, bounce and friction gates, mu * (1 + e).
	logic               vld_s2;
	vel_t               v_s2    [AXES];
	nrm_t               n_s2    [AXES];
	logic signed [35:0] vn_s2;
	logic signed [18:0] ope_s2;
	logic signed [49:0] amu_s2;
	logic               bnc_s2, fok_s2;

	logic signed [49:0] vn30_c, neg_thr_c;
	assign vn30_c    = 50'(vnp_s1[0]) + 50'(vnp_s1[1]) + 50'(vnp_s1[2]);
	assign neg_thr_c = -$signed({5'b0, thr_s1});

	// Stage 3: (1 + e) * vn, friction factor a and |vn|.
	logic               vld_s3;
	vel_t               v_s3    [AXES];
	nrm_t               n_s3    [AXES];
	logic signed [53:0] impm_s3;
	logic [31:0]        a_s3;
	logic [35:0]        vabs_s3;
	logic               bnc_s3, fok_s3;

	// Stage 4: impulse times normal, slip cap product a * |vn|.
	logic               vld_s4;
	vel_t               v_s4    [AXES];
	nrm_t               n_s4    [AXES];
	logic signed [53:0] q_s4    [AXES];
	logic [66:0]        capp_s4;
	logic               bnc_s4, fok_s4;

	logic signed [37:0] imp_c;
	assign imp_c = 38'(impm_s3 >>> 16);

	// Stage 5: reflected velocity w and the saturated slip cap.
	logic               vld_s5;
	logic signed [40:0] w_s5    [AXES];
	nrm_t               n_s5    [AXES];
	logic [CAP_W-1:0]   cap_s5;
	logic               bnc_s5, fok_s5;

	// Stage 6: w_i * n_i.
	logic               vld_s6;
	logic signed [40:0] w_s6    [AXES];
	nrm_t               n_s6    [AXES];
	logic signed [56:0] dwp_s6  [AXES];
	logic [CAP_W-1:0]   cap_s6;
	logic               bnc_s6, fok_s6;

	// Stage 7: normal part of w.
	logic               vld_s7;
	logic signed [40:0] w_s7    [AXES];
	nrm_t               n_s7    [AXES];
	logic signed [44:0] vw_s7;
	logic [CAP_W-1:0]   cap_s7;
	logic               bnc_s7, fok_s7;

	logic signed [58:0] dw_c;
	assign dw_c = 59'(dwp_s6[0]) + 59'(dwp_s6[1]) + 59'(dwp_s6[2]);

	// Stage 8: n_i * vw.
	logic               vld_s8;
	logic signed [40:0] w_s8    [AXES];
	logic signed [60:0] pp_s8   [AXES];
	logic [CAP_W-1:0]   cap_s8;
	logic               bnc_s8, fok_s8;

	// Stage 9: normal projection p and tangent t.
	logic               vld_s9;
	logic signed [40:0] w_s9    [AXES];
	base_t              p_s9    [AXES];
	logic signed [T_W-1:0] t_s9 [AXES];
	logic [CAP_W-1:0]   cap_s9;
	logic               bnc_s9, fok_s9;

	// Stage 10: tangent magnitudes per axis, nonzero tangent.
	logic               vld_s10;
	logic signed [40:0] w_s10   [AXES];
	base_t              p_s10   [AXES];
	logic signed [T_W-1:0] t_s10 [AXES];
	logic [T_W-1:0]     at_s10  [AXES];
	logic [CAP_W-1:0]   cap_s10;
	logic               nz_s10, bnc_s10, fok_s10;

	// Stage 11: scaling shift so every scaled component fits 31 bits.
	logic               vld_s11;
	logic signed [40:0] w_s11   [AXES];
	base_t              p_s11   [AXES];
	logic signed [T_W-1:0] t_s11 [AXES];
	shamt_t             sh_s11;
	logic [CAP_W-1:0]   cap_s11;
	logic               nz_s11, bnc_s11, fok_s11;

	logic [T_W-1:0] orv_c;
	shamt_t         sh_c;
	always_comb begin
		orv_c = at_s10[0] | at_s10[1] | at_s10[2];
		sh_c  = SH_W'(SH_MAX);
		for (int s = SH_MAX; s >= 0; s--) begin
			if ((orv_c >> (s + 31)) == '0) begin
				sh_c = SH_W'(s);
			end
		end
	end

	// Stage 12: scaled tangent, its sign and magnitude, scaled cap, base value.
	logic     vld_s12;
	sq_side_t side_s12;

	logic signed [MAG_W:0] ts_c [AXES];
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			ts_c[i] = (MAG_W+1)'(t_s11[i] >>> sh_s11);
		end
	end

	// Stage 13: squares of the scaled components.
	logic        vld_s13;
	logic [63:0] sq_s13 [AXES];
	sq_side_t    side_s13;

	// Stage 14: squared tangent length.
	logic        vld_s14;
	logic [63:0] sum_s14;
	sq_side_t    side_s14;

	// Square root pipeline.
	logic        sqo_vld;
	mag_t        len_c;
	sq_side_t    sqo_side;

	scvr_isqrt #(
		.RootW  (ROOT_W),
		.side_t (sq_side_t)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s14),
		.rad      (sum_s14),
		.in_side  (side_s14),
		.out_vld  (sqo_vld),
		.root     (len_c),
		.out_side (sqo_side)
	);

	// Stage A: shortened length N = max(L - c, 0).
	logic            vld_sa;
	mag_t            nl_sa;
	mag_t            den_sa;
	mag_t [AXES-1:0] mag_sa;
	dv_side_t        dv_sa;

	// Stage B: numerators |ts_i| * N.
	logic            vld_sb;
	logic [2*MAG_W-1:0] num_sb [AXES];
	mag_t            den_sb;
	dv_side_t        dv_sb;

	// Divider pipeline.
	logic     dvo_vld;
	mag_t     quot_c [AXES];
	dv_side_t dvo_side;

	dv_side_t dvo_in_side_c;
	assign dvo_in_side_c = dv_sb;

	scvr_div #(
		.QuotW  (MAG_W),
		.Lanes  (AXES),
		.side_t (dv_side_t)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_sb),
		.num      (num_sb),
		.den      (den_sb),
		.in_side  (dvo_in_side_c),
		.out_vld  (dvo_vld),
		.quot     (quot_c),
		.out_side (dvo_side)
	);

	// Output stage: rebuild tangent, add the normal part, saturate.
	logic vld_out_q;
	vel_t res_vel_q [AXES];
	logic bounced_q, rubbed_q;

	logic signed [50:0] res_c [AXES];
	vel_t               sat_c [AXES];
	always_comb begin
		logic signed [MAG_W:0] sq;
		for (int i = 0; i < AXES; i++) begin
			sq = dvo_side.neg[i] ? -$signed({1'b0, quot_c[i]}) : $signed({1'b0, quot_c[i]});
			if (dvo_side.rub) begin
				res_c[i] = 51'($signed(dvo_side.base[i])) + (51'(sq) <<< dvo_side.sh);
			end else begin
				res_c[i] = 51'($signed(dvo_side.base[i]));
			end
			if (res_c[i][50:31] == '0 || res_c[i][50:31] == '1) begin
				sat_c[i] = res_c[i][31:0];
			end else begin
				sat_c[i] = res_c[i][50] ? VEL_MIN : VEL_MAX;
			end
		end
	end

	// The pipeline moves whenever the output register is free or being taken.
	assign en         = !vld_out_q || result.ready;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
			vld_s11   <= 1'b0;
			vld_s12   <= 1'b0;
			vld_s13   <= 1'b0;
			vld_s14   <= 1'b0;
			vld_sa    <= 1'b0;
			vld_sb    <= 1'b0;
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= item.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
			vld_s11   <= vld_s10;
			vld_s12   <= vld_s11;
			vld_s13   <= vld_s12;
			vld_s14   <= vld_s13;
			vld_sa    <= sqo_vld;
			vld_sb    <= vld_sa;
			vld_out_q <= dvo_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1
			for (int i = 0; i < AXES; i++) begin
				v_s1[i]   <= vin[i];
				n_s1[i]   <= nin[i];
				vnp_s1[i] <= 48'(vin[i]) * 48'(nin[i]);
			end
			ope_s1 <= ope_c;
			mu_s1  <= item.friction_coeff;
			thr_s1 <= min_q[VEL_W-1] ? '0 : {min_q[VEL_W-2:0], 14'b0};

			// Stage 2
			v_s2   <= v_s1;
			n_s2   <= n_s1;
			vn_s2  <= 36'(vn30_c >>> 14);
			ope_s2 <= ope_s1;
			amu_s2 <= 50'($signed({1'b0, mu_s1[VEL_W-2:0]})) * 50'(ope_s1);
			bnc_s2 <= vn30_c[49];
			fok_s2 <= !mu_s1[VEL_W-1] && (mu_s1 != '0) && (vn30_c < neg_thr_c);

			// Stage 3
			v_s3    <= v_s2;
			n_s3    <= n_s2;
			impm_s3 <= 54'(vn_s2) * 54'(ope_s2);
			a_s3    <= amu_s2[47:16];
			vabs_s3 <= vn_s2[35] ? -vn_s2 : vn_s2;
			bnc_s3  <= bnc_s2;
			fok_s3  <= fok_s2;

			// Stage 4
			v_s4 <= v_s3;
			n_s4 <= n_s3;
			for (int i = 0; i < AXES; i++) begin
				q_s4[i] <= 54'(imp_c) * 54'(n_s3[i]);
			end
			capp_s4 <= 67'(a_s3) * 67'(vabs_s3);
			bnc_s4  <= bnc_s3;
			fok_s4  <= fok_s3;

			// Stage 5: a cap product of 2^63 or more saturates the cap.
			for (int i = 0; i < AXES; i++) begin
				w_s5[i] <= bnc_s4 ? 41'(v_s4[i]) - 41'(q_s4[i] >>> 14) : 41'(v_s4[i]);
			end
			n_s5   <= n_s4;
			cap_s5 <= (capp_s4[66:63] != '0) ? {CAP_W{1'b1}} : capp_s4[62:16];
			bnc_s5 <= bnc_s4;
			fok_s5 <= fok_s4;

			// Stage 6
			w_s6 <= w_s5;
			n_s6 <= n_s5;
			for (int i = 0; i < AXES; i++) begin
				dwp_s6[i] <= 57'(w_s5[i]) * 57'(n_s5[i]);
			end
			cap_s6 <= cap_s5;
			bnc_s6 <= bnc_s5;
			fok_s6 <= fok_s5;

			// Stage 7
			w_s7   <= w_s6;
			n_s7   <= n_s6;
			vw_s7  <= 45'(dw_c >>> 14);
			cap_s7 <= cap_s6;
			bnc_s7 <= bnc_s6;
			fok_s7 <= fok_s6;

			// Stage 8
			w_s8 <= w_s7;
			for (int i = 0; i < AXES; i++) begin
				pp_s8[i] <= 61'(n_s7[i]) * 61'(vw_s7);
			end
			cap_s8 <= cap_s7;
			bnc_s8 <= bnc_s7;
			fok_s8 <= fok_s7;

			// Stage 9
			w_s9 <= w_s8;
			for (int i = 0; i < AXES; i++) begin
				p_s9[i] <= BASE_W'(pp_s8[i] >>> 14);
				t_s9[i] <= T_W'(w_s8[i]) - T_W'(pp_s8[i] >>> 14);
			end
			cap_s9 <= cap_s8;
			bnc_s9 <= bnc_s8;
			fok_s9 <= fok_s8;

			// Stage 10
			w_s10 <= w_s9;
			p_s10 <= p_s9;
			t_s10 <= t_s9;
			for (int i = 0; i < AXES; i++) begin
				at_s10[i] <= t_s9[i][T_W-1] ? -t_s9[i] : t_s9[i];
			end
			nz_s10  <= (t_s9[0] != '0) || (t_s9[1] != '0) || (t_s9[2] != '0);
			cap_s10 <= cap_s9;
			bnc_s10 <= bnc_s9;
			fok_s10 <= fok_s9;

			// Stage 11
			w_s11   <= w_s10;
			p_s11   <= p_s10;
			t_s11   <= t_s10;
			sh_s11  <= sh_c;
			cap_s11 <= cap_s10;
			nz_s11  <= nz_s10;
			bnc_s11 <= bnc_s10;
			fok_s11 <= fok_s10;

			// Stage 12: without friction the base is the reflected velocity.
			for (int i = 0; i < AXES; i++) begin
				side_s12.mag[i]  <= MAG_W'(ts_c[i][MAG_W] ? -ts_c[i] : ts_c[i]);
				side_s12.neg[i]  <= ts_c[i][MAG_W];
				side_s12.base[i] <= (fok_s11 && nz_s11) ? p_s11[i] : BASE_W'(w_s11[i]);
			end
			side_s12.cap_sh <= cap_s11 >> sh_s11;
			side_s12.sh     <= sh_s11;
			side_s12.rub    <= fok_s11 && nz_s11;
			side_s12.bnc    <= bnc_s11;

			// Stage 13
			for (int i = 0; i < AXES; i++) begin
				sq_s13[i] <= 64'(side_s12.mag[i]) * 64'(side_s12.mag[i]);
			end
			side_s13 <= side_s12;

			// Stage 14
			sum_s14  <= sq_s13[0] + sq_s13[1] + sq_s13[2];
			side_s14 <= side_s13;

			// Stage A
			if (CAP_W'(len_c) > sqo_side.cap_sh) begin
				nl_sa <= len_c - MAG_W'(sqo_side.cap_sh);
			end else begin
				nl_sa <= '0;
			end
			den_sa     <= len_c;
			mag_sa     <= sqo_side.mag;
			dv_sa.neg  <= sqo_side.neg;
			dv_sa.base <= sqo_side.base;
			dv_sa.sh   <= sqo_side.sh;
			dv_sa.rub  <= sqo_side.rub;
			dv_sa.bnc  <= sqo_side.bnc;

			// Stage B
			for (int i = 0; i < AXES; i++) begin
				num_sb[i] <= (2*MAG_W)'(mag_sa[i]) * (2*MAG_W)'(nl_sa);
			end
			den_sb <= den_sa;
			dv_sb  <= dv_sa;

			// Output register
			res_vel_q <= sat_c;
			bounced_q <= dvo_side.bnc;
			rubbed_q  <= dvo_side.rub;
		end
	end

	assign result.valid     = vld_out_q;
	assign result.out_vel_x = res_vel_q[0];
	assign result.out_vel_y = res_vel_q[1];
	assign result.out_vel_z = res_vel_q[2];
	assign result.bounced   = bounced_q;
	assign result.rubbed    = rubbed_q;

endmodule
